@@ rtl/core/lamp_brightness_mode_controller_macros.svh @@
// Assertion macros for the lamp brightness mode controller.
// Used by the port checker; depends on nothing else.
`ifndef LAMP_BRIGHTNESS_MODE_CONTROLLER_MACROS_SVH
`define LAMP_BRIGHTNESS_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lbmc_pkg.sv @@
// Shared types and constants of the lamp brightness mode controller.
// Depends on nothing; used by every module of the block and by the checker.
package lbmc_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 12;
    localparam int DUTY_W    = 16;
    localparam int MODE_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP  = 2'd3;

    // Configuration reset values.
    localparam logic [SAMPLE_W-1:0] SETPOINT_RST = 12'd2000;
    localparam logic [SAMPLE_W-1:0] DEADBAND_RST = 12'd300;
    localparam logic [SAMPLE_W-1:0] STEP_RST     = 12'd10;
    localparam logic [DUTY_W-1:0]   PWM_TOP_RST  = 16'd9999;

    // Full-scale ADC reading.
    localparam int ADC_FULL = 4095;

    // Reported modes.
    localparam logic [MODE_W-1:0] MODE_HOLD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SENSOR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ON     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd4;

    // Latched radio requests.
    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_SENSOR = 2'd1;
    localparam logic [1:0] REQ_ON     = 2'd3;

    // Radio command bytes (ASCII 'c' and 'f').
    localparam logic [7:0] CMD_ON     = 8'h63;
    localparam logic [7:0] CMD_SENSOR = 8'h66;

    // How a transaction leaves the duty value.
    typedef enum logic [1:0] {
        DUTY_HOLD = 2'd0,
        DUTY_SET  = 2'd1,
        DUTY_POT  = 2'd2
    } duty_kind_t;

    // Window memory access controls.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } win_ctl_t;

endpackage

@@ rtl/core/lbmc_window_ram.sv @@
// Pot sample window memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses lbmc_pkg.
module lbmc_window_ram #(
    parameter int DEPTH = 100
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  lbmc_pkg::win_ctl_t                       ctl,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [lbmc_pkg::SAMPLE_W-1:0]            wr_data,
    output logic [lbmc_pkg::SAMPLE_W-1:0]            rd_data
);

    logic [lbmc_pkg::SAMPLE_W-1:0] ram [DEPTH];
    logic [DEPTH-1:0]              valid_reg;
    logic [lbmc_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                          rd_valid_reg;
    logic                          fwd;

    // A read of the entry being written this cycle takes the new data.
    assign fwd = ctl.rd_en && ctl.wr_en && (rd_addr == wr_addr);

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
    end

    // Valid bits, cleared at reset and set by the first write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read data; held while no read is issued.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= fwd ? wr_data : ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            rd_valid_reg <= fwd | valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/lamp_brightness_mode_controller.sv @@
// Top level of the lamp brightness mode controller.
// Depends on lbmc_pkg and instantiates the window memory lbmc_window_ram.
//
// The block accepts one transaction per clock cycle while its input side is
// ready, and presents each result after it has passed stage 1 to stage 5 and
// the output stage. Every stage moves on into a free stage; a
// waiting result stalls new input only once all six stages hold a transaction.
// Along the way lie the window read-modify-write (a synchronous memory
// read, then the sum update and write-back), the reciprocal multiply for the
// window average, the pwm_top multiply and a two-step division by 4095. The
// window memory has a valid bit per entry cleared at reset, so there is no
// clearing pass and the block is ready straight out of reset. Configuration
// writes take effect at once and must only be made while the block is idle.
module lamp_brightness_mode_controller #(
    parameter int WINDOW_LEN = 100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port.
    input  logic                               cfg_wr_en,
    input  logic [lbmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbmc_pkg::CFG_W-1:0]         cfg_data,
    // Input channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               btn_sensor_mode,
    input  logic                               btn_pot_mode,
    input  logic                               btn_lamp_on,
    input  logic                               btn_lamp_off,
    input  logic [lbmc_pkg::SAMPLE_W-1:0]      sensor_sample,
    input  logic [lbmc_pkg::SAMPLE_W-1:0]      pot_sample,
    input  logic                               msg_valid,
    input  logic [7:0]                         msg_byte,
    // Output channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lbmc_pkg::DUTY_W-1:0]        duty,
    output logic [lbmc_pkg::MODE_W-1:0]        mode_taken,
    output logic [lbmc_pkg::SAMPLE_W-1:0]      pot_average
);

    localparam int SW_    = lbmc_pkg::SAMPLE_W;
    localparam int DW     = lbmc_pkg::DUTY_W;
    localparam int MW     = lbmc_pkg::MODE_W;
    localparam int AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUMW   = $clog2(WINDOW_LEN * lbmc_pkg::ADC_FULL + 1);
    localparam int DLOG   = $clog2(WINDOW_LEN);
    localparam int SHIFT  = SUMW + DLOG;
    localparam int PRODW  = 2 * SUMW + 1;
    localparam int PW     = SW_ + DW;
    localparam int RW     = SW_ + 2;
    localparam logic [SUMW:0] RECIP = (SUMW + 1)'(((64'd1 << SHIFT)
        + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic [AW-1:0] POS_LAST = AW'(WINDOW_LEN - 1);
    localparam logic [RW-1:0] DIV_ONE  = RW'(lbmc_pkg::ADC_FULL);
    localparam logic [RW-1:0] DIV_TWO  = RW'(2 * lbmc_pkg::ADC_FULL);

    // Configuration registers.
    logic [SW_-1:0] setpoint_reg;
    logic [SW_-1:0] deadband_reg;
    logic [SW_-1:0] step_reg;
    logic [DW-1:0]  pwm_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= lbmc_pkg::SETPOINT_RST;
            deadband_reg <= lbmc_pkg::DEADBAND_RST;
            step_reg     <= lbmc_pkg::STEP_RST;
            pwm_top_reg  <= lbmc_pkg::PWM_TOP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lbmc_pkg::REG_SETPOINT: setpoint_reg <= cfg_data[SW_-1:0];
                lbmc_pkg::REG_DEADBAND: deadband_reg <= cfg_data[SW_-1:0];
                lbmc_pkg::REG_STEP:     step_reg     <= cfg_data[SW_-1:0];
                lbmc_pkg::REG_PWM_TOP:  pwm_top_reg  <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and the ready chain; a stage loads when it is empty or
    // its item moves on.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
    logic accept;

    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy5     = !v5_reg || rdy_out;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign accept   = in_valid && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)    v1_reg        <= in_valid;
            if (rdy2)    v2_reg        <= v1_reg;
            if (rdy3)    v3_reg        <= v2_reg;
            if (rdy4)    v4_reg        <= v3_reg;
            if (rdy5)    v5_reg        <= v4_reg;
            if (rdy_out) out_valid_reg <= v5_reg;
        end
    end

    // Front state: radio latch, lamp level and window position.
    logic [1:0]    remote_request_reg, remote_request_next;
    logic [DW-1:0] lamp_level_reg, lamp_level_next;
    logic [AW-1:0] window_pos_reg, window_pos_next;

    // Mode selection and sensor regulation for the arriving transaction.
    logic                     [MW-1:0] mode0;
    lbmc_pkg::duty_kind_t              kind0;
    logic                     [DW-1:0] set_val0;
    logic signed [SW_+1:0]             lo_edge;
    logic        [SW_:0]               hi_edge;
    logic                              below, above;
    logic        [DW:0]                up_sum;
    logic        [DW-1:0]              level_up, level_down;

    always_comb
    begin
        remote_request_next = remote_request_reg;
        if (msg_valid && (msg_byte == lbmc_pkg::CMD_ON))
        begin
            remote_request_next = lbmc_pkg::REQ_ON;
        end
        else if (msg_valid && (msg_byte == lbmc_pkg::CMD_SENSOR))
        begin
            remote_request_next = lbmc_pkg::REQ_SENSOR;
        end

        if (btn_sensor_mode)                                   mode0 = lbmc_pkg::MODE_SENSOR;
        else if (btn_pot_mode)                                 mode0 = lbmc_pkg::MODE_POT;
        else if (btn_lamp_on)                                  mode0 = lbmc_pkg::MODE_ON;
        else if (btn_lamp_off)                                 mode0 = lbmc_pkg::MODE_OFF;
        else if (remote_request_next == lbmc_pkg::REQ_ON)      mode0 = lbmc_pkg::MODE_ON;
        else if (remote_request_next == lbmc_pkg::REQ_SENSOR)  mode0 = lbmc_pkg::MODE_SENSOR;
        else                                                   mode0 = lbmc_pkg::MODE_HOLD;
    end

    // The lower band edge may fall below zero, so it is compared signed.
    assign lo_edge    = $signed({2'b00, setpoint_reg}) - $signed({2'b00, deadband_reg});
    assign hi_edge    = {1'b0, setpoint_reg} + {1'b0, deadband_reg};
    assign below      = $signed({2'b00, sensor_sample}) < lo_edge;
    assign above      = {1'b0, sensor_sample} > hi_edge;
    assign up_sum     = {1'b0, lamp_level_reg} + (DW + 1)'(step_reg);
    assign level_up   = (up_sum > {1'b0, pwm_top_reg}) ? pwm_top_reg : up_sum[DW-1:0];
    assign level_down = (lamp_level_reg > DW'(step_reg)) ?
                        (lamp_level_reg - DW'(step_reg)) : '0;

    always_comb
    begin
        kind0           = lbmc_pkg::DUTY_HOLD;
        set_val0        = '0;
        lamp_level_next = lamp_level_reg;
        case (mode0)
            lbmc_pkg::MODE_SENSOR:
            begin
                if (below)
                begin
                    kind0           = lbmc_pkg::DUTY_SET;
                    set_val0        = level_up;
                    lamp_level_next = level_up;
                end
                else if (above)
                begin
                    kind0           = lbmc_pkg::DUTY_SET;
                    set_val0        = level_down;
                    lamp_level_next = level_down;
                end
            end
            lbmc_pkg::MODE_POT:
            begin
                kind0 = lbmc_pkg::DUTY_POT;
            end
            lbmc_pkg::MODE_ON:
            begin
                kind0    = lbmc_pkg::DUTY_SET;
                set_val0 = pwm_top_reg;
            end
            lbmc_pkg::MODE_OFF:
            begin
                kind0    = lbmc_pkg::DUTY_SET;
                set_val0 = '0;
            end
            default: ;
        endcase
    end

    // Only pot transactions advance the window position.
    always_comb
    begin
        window_pos_next = window_pos_reg;
        if (mode0 == lbmc_pkg::MODE_POT)
        begin
            window_pos_next = (window_pos_reg == POS_LAST) ? '0 : (window_pos_reg + AW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_request_reg <= lbmc_pkg::REQ_NONE;
            lamp_level_reg     <= '0;
            window_pos_reg     <= '0;
        end
        else if (accept)
        begin
            remote_request_reg <= remote_request_next;
            lamp_level_reg     <= lamp_level_next;
            window_pos_reg     <= window_pos_next;
        end
    end

    // Stage 1: oldest window entry arrives from memory.
    lbmc_pkg::duty_kind_t s1_kind_reg;
    logic [DW-1:0]        s1_val_reg;
    logic [MW-1:0]        s1_mode_reg;
    logic [SW_-1:0]       s1_sample_reg;
    logic [AW-1:0]        s1_addr_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_kind_reg   <= kind0;
            s1_val_reg    <= set_val0;
            s1_mode_reg   <= mode0;
            s1_sample_reg <= pot_sample;
            s1_addr_reg   <= window_pos_reg;
        end
    end

    // Window memory read-modify-write.
    lbmc_pkg::win_ctl_t win_ctl;
    logic [SW_-1:0]     win_old;
    logic               s1_write;

    assign s1_write      = v1_reg && rdy2 && (s1_kind_reg == lbmc_pkg::DUTY_POT);
    assign win_ctl.rd_en = accept;
    assign win_ctl.wr_en = s1_write;

    lbmc_window_ram #(
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win_ctl),
        .rd_addr (window_pos_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_sample_reg),
        .rd_data (win_old)
    );

    // Running window sum; never exceeds the window length times full scale.
    logic [SUMW-1:0] window_sum_reg;
    logic [SUMW-1:0] sum_new;
    logic [SUMW-1:0] sum_after;

    assign sum_new   = window_sum_reg - SUMW'(win_old) + SUMW'(s1_sample_reg);
    assign sum_after = (s1_kind_reg == lbmc_pkg::DUTY_POT) ? sum_new : window_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg <= '0;
        end
        else if (s1_write)
        begin
            window_sum_reg <= sum_new;
        end
    end

    // Stage 2: sum snapshot after this transaction.
    lbmc_pkg::duty_kind_t s2_kind_reg;
    logic [DW-1:0]        s2_val_reg;
    logic [MW-1:0]        s2_mode_reg;
    logic [SUMW-1:0]      s2_sum_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_val_reg  <= s1_val_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_sum_reg  <= sum_after;
        end
    end

    // Stage 3: average by multiplication with the rounded-up reciprocal.
    lbmc_pkg::duty_kind_t s3_kind_reg;
    logic [DW-1:0]        s3_val_reg;
    logic [MW-1:0]        s3_mode_reg;
    logic [SW_-1:0]       s3_avg_reg;
    logic [PRODW-1:0]     recip_prod;

    assign recip_prod = PRODW'(s2_sum_reg) * PRODW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_val_reg  <= s2_val_reg;
            s3_mode_reg <= s2_mode_reg;
            s3_avg_reg  <= recip_prod[SHIFT +: SW_];
        end
    end

    // Stage 4: average scaled by pwm_top.
    lbmc_pkg::duty_kind_t s4_kind_reg;
    logic [DW-1:0]        s4_val_reg;
    logic [MW-1:0]        s4_mode_reg;
    logic [SW_-1:0]       s4_avg_reg;
    logic [PW-1:0]        s4_prod_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_val_reg  <= s3_val_reg;
            s4_mode_reg <= s3_mode_reg;
            s4_avg_reg  <= s3_avg_reg;
            s4_prod_reg <= PW'(s3_avg_reg) * PW'(pwm_top_reg);
        end
    end

    // Stage 5: estimate of product / 4095 from shifted copies and its
    // remainder; the estimate is at most two below the true quotient.
    lbmc_pkg::duty_kind_t s5_kind_reg;
    logic [DW-1:0]        s5_val_reg;
    logic [MW-1:0]        s5_mode_reg;
    logic [SW_-1:0]       s5_avg_reg;
    logic [DW:0]          s5_q0_reg;
    logic [RW-1:0]        s5_rem_reg;
    logic [DW:0]          q0;
    logic [PW:0]          rem_full;

    assign q0       = {1'b0, s4_prod_reg[PW-1:SW_]} + (DW + 1)'(s4_prod_reg[PW-1:2*SW_]);
    assign rem_full = {1'b0, s4_prod_reg} - {q0, {SW_{1'b0}}} + (PW + 1)'(q0);

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            s5_kind_reg <= s4_kind_reg;
            s5_val_reg  <= s4_val_reg;
            s5_mode_reg <= s4_mode_reg;
            s5_avg_reg  <= s4_avg_reg;
            s5_q0_reg   <= q0;
            s5_rem_reg  <= rem_full[RW-1:0];
        end
    end

    // Output stage: quotient correction and the held duty value.
    logic [DW:0]          q_fix;
    logic [DW-1:0]        duty_reg, duty_next;
    logic [MW-1:0]        mode_reg;
    logic [SW_-1:0]       avg_reg;

    always_comb
    begin
        if (s5_rem_reg >= DIV_TWO)
        begin
            q_fix = s5_q0_reg + (DW + 1)'(2);
        end
        else if (s5_rem_reg >= DIV_ONE)
        begin
            q_fix = s5_q0_reg + (DW + 1)'(1);
        end
        else
        begin
            q_fix = s5_q0_reg;
        end

        case (s5_kind_reg)
            lbmc_pkg::DUTY_SET: duty_next = s5_val_reg;
            lbmc_pkg::DUTY_POT: duty_next = q_fix[DW-1:0];
            default:            duty_next = duty_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0;
        end
        else if (v5_reg && rdy_out)
        begin
            duty_reg <= duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v5_reg && rdy_out)
        begin
            mode_reg <= s5_mode_reg;
            avg_reg  <= s5_avg_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty        = duty_reg;
    assign mode_taken  = mode_reg;
    assign pot_average = avg_reg;

endmodule

@@ rtl/core/lbmc_checker.sv @@
// Port-level checker for the lamp brightness mode controller, with its bind.
// Depends on lbmc_pkg and lamp_brightness_mode_controller_macros.svh.
`include "lamp_brightness_mode_controller_macros.svh"

module lbmc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lbmc_pkg::DUTY_W-1:0]   duty,
    input logic [lbmc_pkg::MODE_W-1:0]   mode_taken
);

    // A stalled result transaction keeps its duty value.
    `LBMC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(duty), "stalled result changed")

    // Off mode always drives the lamp to zero duty.
    `LBMC_ASSERT_IMP(a_off_zero, clk, rst_n, out_valid && (mode_taken == lbmc_pkg::MODE_OFF), duty == '0, "off mode with non-zero duty")

    // A held pass repeats the duty of the result delivered just before it.
    `LBMC_ASSERT_IMP(a_hold_keeps, clk, rst_n, (out_valid && out_ready) ##1 (out_valid && (mode_taken == lbmc_pkg::MODE_HOLD)), duty == $past(duty), "held pass changed duty")

endmodule

bind lamp_brightness_mode_controller lbmc_checker u_lbmc_checker (.*);

@@ tb/sv/lamp_brightness_mode_controller_test.sv @@
// Self-checking testbench for the lamp brightness mode controller.
// Depends on lbmc_pkg and on the lamp_brightness_mode_controller RTL; it drives
// a directed table, then random control passes over many register settings.
module lamp_brightness_mode_controller_test;
    import lbmc_pkg::*;

    localparam int WIN_LEN      = 100;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASE_COUNT  = 10;
    localparam int SETTLE       = 12;
    localparam int DRAIN_MAX    = 5000;
    localparam int LIMIT_CYCLES = 400000;
    localparam int STALL_AT     = 320;
    localparam int STALL_LEN    = 250;

    // One control pass as offered on the input channel.
    typedef struct packed {
        logic                btn_sensor;
        logic                btn_pot;
        logic                btn_on;
        logic                btn_off;
        logic [SAMPLE_W-1:0] sensor;
        logic [SAMPLE_W-1:0] pot;
        logic                msg_valid;
        logic [7:0]          msg_byte;
    } lamp_pass_in_t;

    // What one pass leaves on the output channel.
    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] average;
    } lamp_outcome_t;

    typedef struct packed {
        lamp_pass_in_t pass;
        logic          typed;
        lamp_outcome_t want;
    } directed_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic                btn_sensor_mode;
    logic                btn_pot_mode;
    logic                btn_lamp_on;
    logic                btn_lamp_off;
    logic [SAMPLE_W-1:0] sensor_sample;
    logic [SAMPLE_W-1:0] pot_sample;
    logic                msg_valid;
    logic [7:0]          msg_byte;
    logic                out_valid;
    logic                out_ready;
    logic [DUTY_W-1:0]   duty;
    logic [MODE_W-1:0]   mode_taken;
    logic [SAMPLE_W-1:0] pot_average;

    // Predictor copy of the registers and of the block state.
    int            cfg_setpoint = int'(SETPOINT_RST);
    int            cfg_deadband = int'(DEADBAND_RST);
    int            cfg_step     = int'(STEP_RST);
    int            cfg_pwm_top  = int'(PWM_TOP_RST);
    logic [1:0]    radio_latch  = REQ_NONE;
    int            level_now    = 0;
    logic [DUTY_W-1:0] duty_now = '0;
    int            pot_win[WIN_LEN];
    int            win_pos      = 0;
    int            win_sum      = 0;

    // Expected outcomes in order of acceptance.
    lamp_outcome_t pending_outcomes[$];
    directed_row_t directed_rows[$];

    // Literal expectation for the transaction currently offered.
    logic          lit_typed;
    lamp_outcome_t lit_outcome;

    logic          calm;
    int            cycle_count    = 0;
    int            passes_taken   = 0;
    int            results_seen   = 0;
    int            mismatches     = 0;
    int            pot_passes     = 0;
    int            sensor_passes  = 0;
    int            settings_used  = 0;

    lamp_brightness_mode_controller #(
        .WINDOW_LEN (WIN_LEN)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .btn_sensor_mode (btn_sensor_mode),
        .btn_pot_mode    (btn_pot_mode),
        .btn_lamp_on     (btn_lamp_on),
        .btn_lamp_off    (btn_lamp_off),
        .sensor_sample   (sensor_sample),
        .pot_sample      (pot_sample),
        .msg_valid       (msg_valid),
        .msg_byte        (msg_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .duty            (duty),
        .mode_taken      (mode_taken),
        .pot_average     (pot_average)
    );

    // Free-running clock, period 10.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the outcome of one pass and advances the predictor state.
    function automatic lamp_outcome_t predict_lamp_pass(lamp_pass_in_t p);
        lamp_outcome_t     o;
        logic [MODE_W-1:0] mode;
        int                lower_edge;
        int                upper_edge;
        int                raised;
        int                avg;
        if (p.msg_valid)
        begin
            if (p.msg_byte == CMD_ON)
                radio_latch = REQ_ON;
            else if (p.msg_byte == CMD_SENSOR)
                radio_latch = REQ_SENSOR;
        end
        if (p.btn_sensor)
            mode = MODE_SENSOR;
        else if (p.btn_pot)
            mode = MODE_POT;
        else if (p.btn_on)
            mode = MODE_ON;
        else if (p.btn_off)
            mode = MODE_OFF;
        else if (radio_latch == REQ_ON)
            mode = MODE_ON;
        else if (radio_latch == REQ_SENSOR)
            mode = MODE_SENSOR;
        else
            mode = MODE_HOLD;
        case (mode)
            MODE_SENSOR:
            begin
                // The band edges are signed, so the lower one may sit below zero.
                lower_edge = cfg_setpoint - cfg_deadband;
                upper_edge = cfg_setpoint + cfg_deadband;
                if (int'(p.sensor) < lower_edge)
                begin
                    raised = level_now + cfg_step;
                    level_now = (raised > cfg_pwm_top) ? cfg_pwm_top : raised;
                    duty_now = DUTY_W'(level_now);
                end
                else if (int'(p.sensor) > upper_edge)
                begin
                    level_now = (level_now > cfg_step) ? level_now - cfg_step : 0;
                    duty_now = DUTY_W'(level_now);
                end
            end
            MODE_POT:
            begin
                win_sum = win_sum - pot_win[win_pos] + int'(p.pot);
                pot_win[win_pos] = int'(p.pot);
                win_pos = (win_pos + 1 >= WIN_LEN) ? 0 : win_pos + 1;
                avg = win_sum / WIN_LEN;
                duty_now = DUTY_W'((longint'(avg) * longint'(cfg_pwm_top)) / ADC_FULL);
            end
            MODE_ON:
                duty_now = DUTY_W'(cfg_pwm_top);
            MODE_OFF:
                duty_now = '0;
            default:
                ;
        endcase
        o.duty    = duty_now;
        o.mode    = mode;
        o.average = SAMPLE_W'(win_sum / WIN_LEN);
        return o;
    endfunction

    // Sampling at the rising edge: register writes, accepted passes and results.
    always @(posedge clk)
    begin
        lamp_outcome_t predicted;
        lamp_outcome_t oldest;
        lamp_pass_in_t taken;
        cycle_count++;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SETPOINT: cfg_setpoint = int'(cfg_data[SAMPLE_W-1:0]);
                    REG_DEADBAND: cfg_deadband = int'(cfg_data[SAMPLE_W-1:0]);
                    REG_STEP:     cfg_step     = int'(cfg_data[SAMPLE_W-1:0]);
                    REG_PWM_TOP:  cfg_pwm_top  = int'(cfg_data);
                    default:      ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                taken = '{btn_sensor_mode, btn_pot_mode, btn_lamp_on, btn_lamp_off,
                          sensor_sample, pot_sample, msg_valid, msg_byte};
                predicted = predict_lamp_pass(taken);
                if (predicted.mode == MODE_POT)
                    pot_passes++;
                if (predicted.mode == MODE_SENSOR)
                    sensor_passes++;
                pending_outcomes.push_back(lit_typed ? lit_outcome : predicted);
                passes_taken++;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected: duty %0d mode %0d avg %0d",
                             $time, duty, mode_taken, pot_average);
                end
                else
                begin
                    oldest = pending_outcomes.pop_front();
                    if (duty !== oldest.duty)
                    begin
                        mismatches++;
                        $display("%0t: duty expected %0d actual %0d",
                                 $time, oldest.duty, duty);
                    end
                    if (mode_taken !== oldest.mode)
                    begin
                        mismatches++;
                        $display("%0t: mode_taken expected %0d actual %0d",
                                 $time, oldest.mode, mode_taken);
                    end
                    if (pot_average !== oldest.average)
                    begin
                        mismatches++;
                        $display("%0t: pot_average expected %0d actual %0d",
                                 $time, oldest.average, pot_average);
                    end
                end
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off so the block fills.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && passes_taken >= STALL_AT)
            begin
                hold_done = 1'b1;
                hold_left = STALL_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = calm || ($urandom_range(99) >= 35);
            end
        end
    end

    // Cycle limit on the whole run.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    task automatic add_row(input int s, input int p, input int on, input int off,
                           input int sens, input int pot, input int mv, input logic [7:0] mb,
                           input int typed, input int want_duty,
                           input logic [MODE_W-1:0] want_mode, input int want_avg);
        directed_row_t r;
        r.pass    = '{1'(s), 1'(p), 1'(on), 1'(off), SAMPLE_W'(sens), SAMPLE_W'(pot),
                      1'(mv), mb};
        r.typed   = 1'(typed);
        r.want    = '{DUTY_W'(want_duty), want_mode, SAMPLE_W'(want_avg)};
        directed_rows.push_back(r);
    endtask

    // Offers one transaction, with random idle cycles before it, and waits for it.
    task automatic send_pass(input lamp_pass_in_t p, input logic typed,
                             input lamp_outcome_t want);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {btn_sensor_mode, btn_pot_mode, btn_lamp_on, btn_lamp_off,
         sensor_sample, pot_sample, msg_valid, msg_byte} = p;
        lit_typed   = typed;
        lit_outcome = want;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Lets every outstanding result drain, within a bound, then waits out the SETTLE interval.
    task automatic wait_idle();
        int waited;
        waited = 0;
        in_valid = 1'b0;
        while (pending_outcomes.size() != 0 && waited < DRAIN_MAX)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apply_settings(input int sp, input int db, input int st, input int pt);
        logic [CFG_IDX_W-1:0] idx [4];
        int                   val [4];
        idx = '{REG_SETPOINT, REG_DEADBAND, REG_STEP, REG_PWM_TOP};
        val = '{sp, db, st, pt};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en = 1'b1;
            cfg_index = idx[i];
            cfg_data  = CFG_W'(val[i]);
            @(negedge clk);
        end
        cfg_wr_en = 1'b0;
        settings_used++;
    endtask

    // Main stimulus: reset, directed table, then random phases over several settings.
    initial
    begin
        lamp_pass_in_t p;
        lamp_outcome_t none;
        int            kind;
        int            pick;
        int            sens;
        int            sp;
        int            db;
        int            st;
        int            pt;
        none      = '0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SETPOINT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        {btn_sensor_mode, btn_pot_mode, btn_lamp_on, btn_lamp_off,
         sensor_sample, pot_sample, msg_valid, msg_byte} = '0;
        lit_typed   = 1'b0;
        lit_outcome = '0;
        for (int i = 0; i < WIN_LEN; i++)
            pot_win[i] = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values first, then button priority, band edges and saturation.
        add_row(0, 0, 0, 0, 0,    0,    0, 8'h00, 1, 0,    MODE_HOLD,   0);
        add_row(0, 0, 1, 0, 0,    0,    0, 8'h00, 1, 9999, MODE_ON,     0);
        add_row(0, 0, 0, 1, 0,    0,    0, 8'h00, 1, 0,    MODE_OFF,    0);
        add_row(1, 0, 0, 0, 0,    0,    0, 8'h00, 1, 10,   MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 0,    0,    0, 8'h00, 1, 20,   MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 2000, 0,    0, 8'h00, 1, 20,   MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 4095, 0,    0, 8'h00, 1, 10,   MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 4095, 0,    0, 8'h00, 1, 0,    MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 4095, 0,    0, 8'h00, 1, 0,    MODE_SENSOR, 0);
        add_row(1, 1, 1, 1, 1700, 4095, 0, 8'h00, 1, 0,    MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 2300, 0,    0, 8'h00, 1, 0,    MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 1699, 0,    0, 8'h00, 1, 10,   MODE_SENSOR, 0);
        add_row(1, 0, 0, 0, 2301, 0,    0, 8'h00, 1, 0,    MODE_SENSOR, 0);
        // Pot window and the radio latch, checked by the predictor.
        add_row(0, 1, 1, 1, 0,    4095, 0, 8'h00, 0, 0, MODE_HOLD, 0);
        add_row(0, 1, 0, 0, 4095, 4095, 1, 8'hFF, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 0, 0, 0,    0,    1, CMD_ON, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 0, 0, 0,    0,    1, 8'h78, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 0, 0, 0,    0,    0, CMD_SENSOR, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 0, 0, 0,    0,    1, CMD_SENSOR, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 0, 0, 0,    0,    0, 8'h00, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 0, 1, 0,    0,    1, CMD_ON, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 0, 0, 4095, 0,    0, 8'h00, 0, 0, MODE_HOLD, 0);
        add_row(0, 1, 0, 0, 0,    0,    0, 8'h00, 0, 0, MODE_HOLD, 0);
        add_row(0, 0, 1, 0, 0,    0,    1, CMD_SENSOR, 0, 0, MODE_HOLD, 0);
        foreach (directed_rows[i])
            send_pass(directed_rows[i].pass, directed_rows[i].typed, directed_rows[i].want);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_idle();
            case (ph)
                0: begin sp = 0;    db = 0;    st = 1;    pt = 1;     end
                1: begin sp = 4095; db = 4095; st = 4095; pt = 65535; end
                2: begin sp = 100;  db = 4095; st = 50;   pt = 20000; end
                3: begin sp = 3000; db = 0;    st = 4095; pt = 65535; end
                4: begin sp = 1000; db = 200;  st = 0;    pt = 0;     end
                5: begin sp = 2000; db = 300;  st = 10;   pt = 9999;  end
                6: begin sp = 2048; db = 100;  st = 700;  pt = 30000; end
                7: begin sp = 2048; db = 50;   st = 300;  pt = 500;   end
                default:
                begin
                    sp = $urandom_range(4095);
                    db = $urandom_range(1500);
                    st = $urandom_range(4095, 1);
                    pt = $urandom_range(65535, 1);
                end
            endcase
            apply_settings(sp, db, st, pt);
            // One phase runs with no idling on either side.
            calm = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p = '0;
                kind = $urandom_range(99);
                if (kind < 22)
                begin
                    p.btn_sensor = 1'b0;
                end
                else if (kind < 45)
                begin
                    p.btn_sensor = 1'b1;
                    {p.btn_pot, p.btn_on, p.btn_off} = 3'($urandom);
                end
                else if (kind < 70)
                begin
                    p.btn_pot = 1'b1;
                    {p.btn_on, p.btn_off} = 2'($urandom);
                end
                else if (kind < 80)
                begin
                    p.btn_on  = 1'b1;
                    p.btn_off = 1'($urandom);
                end
                else if (kind < 88)
                begin
                    p.btn_off = 1'b1;
                end
                else
                begin
                    {p.btn_sensor, p.btn_pot, p.btn_on, p.btn_off} = 4'($urandom);
                end
                p.msg_valid = ($urandom_range(99) < 35);
                pick = $urandom_range(9);
                p.msg_byte = (pick < 3) ? CMD_ON : (pick < 6) ? CMD_SENSOR : 8'($urandom);
                // Sensor samples crowd the band edges and the rails.
                pick = $urandom_range(9);
                case (pick)
                    0:       sens = cfg_setpoint - cfg_deadband - 1;
                    1:       sens = cfg_setpoint - cfg_deadband;
                    2:       sens = cfg_setpoint + cfg_deadband;
                    3:       sens = cfg_setpoint + cfg_deadband + 1;
                    4:       sens = 0;
                    5:       sens = 4095;
                    default: sens = $urandom_range(4095);
                endcase
                sens = (sens < 0) ? 0 : (sens > 4095) ? 4095 : sens;
                p.sensor = SAMPLE_W'(sens);
                pick = $urandom_range(9);
                p.pot = (pick == 0) ? '0 : (pick == 1) ? 12'hFFF : SAMPLE_W'($urandom);
                send_pass(p, 1'b0, none);
            end
        end
        calm = 1'b0;

        wait_idle();
        if (pending_outcomes.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived, expected 0 actual %0d",
                     $time, pending_outcomes.size(), pending_outcomes.size());
        end
        $display("Run covered %0d passes (%0d pot, %0d sensor) over %0d register settings,",
                 passes_taken, pot_passes, sensor_passes, settings_used + 1);
        $display("with %0d results checked and one long output stall; %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
